[hdl/klt_pkg.sv]
// ----------------------------------------------------------------------------
// klt_pkg
// Types, token classes and the keyword table of the keyword lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package klt_pkg;

	// Widths of the item fields and sizes of the keyword table
	localparam int CHAR_W   = 8;
	localparam int TOK_W    = 16;
	localparam int KW_NUM   = 14;
	localparam int KW_CHARS = 16;

	// Request codes
	typedef enum logic {
		REQ_CHAR = 1'b0,
		REQ_END  = 1'b1
	} req_t;

	// Scanner modes
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_STR  = 2'd2
	} mode_t;

	// Token classes
	typedef enum logic [3:0] {
		CL_NUMBER   = 4'd0,
		CL_STRING   = 4'd1,
		CL_NUMDECL  = 4'd2,
		CL_STRDECL  = 4'd3,
		CL_KEYWORD  = 4'd4,
		CL_CONSTANT = 4'd5,
		CL_IDENT    = 4'd6,
		CL_OP       = 4'd7,
		CL_EQUAL    = 4'd8,
		CL_LBRACE   = 4'd9,
		CL_RBRACE   = 4'd10,
		CL_FUNCDECL = 4'd11,
		CL_UNKNOWN  = 4'd12
	} tok_class_t;

	typedef struct packed {
		logic              req_type;
		logic [CHAR_W-1:0] char_code;
	} src_item_t;

	typedef struct packed {
		tok_class_t       token_class;
		logic [TOK_W-1:0] token_start;
		logic [TOK_W-1:0] token_length;
		logic             last;
	} tok_item_t;

	// Keyword text, right-justified, last character in the low byte
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
		(8*KW_CHARS)'("textong"),
		(8*KW_CHARS)'("numerong"),
		(8*KW_CHARS)'("bilang"),
		(8*KW_CHARS)'("let"),
		(8*KW_CHARS)'("const"),
		(8*KW_CHARS)'("para"),
		(8*KW_CHARS)'("sa"),
		(8*KW_CHARS)'("mula"),
		(8*KW_CHARS)'("hanggang"),
		(8*KW_CHARS)'("pamamaraan"),
		(8*KW_CHARS)'("na"),
		(8*KW_CHARS)'("namayroong"),
		(8*KW_CHARS)'("at"),
		(8*KW_CHARS)'("katapusan")
	};

	localparam logic [3:0] KW_LEN [KW_NUM] = '{
		4'd7, 4'd8, 4'd6, 4'd3, 4'd5, 4'd4, 4'd2,
		4'd4, 4'd8, 4'd10, 4'd2, 4'd10, 4'd2, 4'd9
	};

	localparam tok_class_t KW_CLASS [KW_NUM] = '{
		CL_STRDECL, CL_NUMDECL, CL_EQUAL, CL_KEYWORD, CL_CONSTANT, CL_KEYWORD,
		CL_KEYWORD, CL_EQUAL, CL_KEYWORD, CL_FUNCDECL, CL_KEYWORD, CL_KEYWORD,
		CL_KEYWORD, CL_KEYWORD
	};

	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

	// Character at offset idx of keyword k (meaningless when idx >= length)
	function automatic logic [CHAR_W-1:0] kw_char(input int unsigned k,
			input logic [3:0] idx);
		logic [3:0] sel;
		sel = KW_LEN[k] - 4'd1 - idx;
		return KW_TEXT[k][{sel, 3'b000} +: 8];
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
	endfunction

endpackage

`default_nettype wire

[hdl/keyword_lexer_tokenizer.sv]
// ----------------------------------------------------------------------------
// keyword_lexer_tokenizer
// Streaming lexer: one source character per item in, token spans out.
// ----------------------------------------------------------------------------
// Each accepted item is scanned in the cycle it is accepted: the scanner state
// (mode, position, pending span, keyword match mask) updates at that edge and
// the zero, one or two tokens it causes enter a four-entry result queue. The
// queue feeds the output one token per cycle while tok_stall is low. Items
// are taken every cycle while the queue has room for two tokens, so with no
// token stall the sustained rate is one item per cycle; a run of items that
// each close a word and add a one-character token is bounded by the output
// at one token per cycle. A token reaches the output no sooner than the
// cycle after its item is accepted, later when older tokens are still queued.
// End of source flushes any open word or string and resets the scanner state.
`default_nettype none

module keyword_lexer_tokenizer
	import klt_pkg::*;
#(
	parameter int POS_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_stall,
	input  wire src_item_t src_item,
	output logic           tok_valid,
	input  wire logic      tok_stall,
	output tok_item_t      tok_item
);

	localparam int QD = 4;
	localparam int QA = $clog2(QD);

	// Scanner state
	mode_t               mode_q;
	logic [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] pstart_q;
	logic [POS_BITS-1:0] plen_q;
	logic [KW_NUM-1:0]   alive_q;
	logic                digit_q;
	logic                letter_q;

	mode_t               mode_d;
	logic [POS_BITS-1:0] pos_d;
	logic [POS_BITS-1:0] pstart_d;
	logic [POS_BITS-1:0] plen_d;
	logic [KW_NUM-1:0]   alive_d;
	logic                digit_d;
	logic                letter_d;

	// Result queue
	tok_item_t       queue_q [QD];
	logic [QA-1:0]   wr_q;
	logic [QA-1:0]   rd_q;
	logic [QA:0]     count_q;

	tok_item_t       res0;
	tok_item_t       res1;
	logic [1:0]      nres;
	logic            accept;
	logic            pop;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == '1) ? v : v + POS_BITS'(1);
	endfunction

	// Class of the word held in the given state
	function automatic tok_class_t word_class(input logic [KW_NUM-1:0] alive,
			input logic [POS_BITS-1:0] len, input logic dig, input logic let_seen);
		tok_class_t cls;
		logic       hit;
		hit = 1'b0;
		if (!let_seen) begin
			cls = CL_NUMBER;
		end else if (!dig) begin
			cls = CL_IDENT;
		end else begin
			cls = CL_UNKNOWN;
		end
		for (int k = KW_NUM - 1; k >= 0; k--) begin
			if (alive[k] && (len == POS_BITS'(KW_LEN[k]))) begin
				cls = KW_CLASS[k];
				hit = 1'b1;
			end
		end
		return hit ? cls : cls;
	endfunction

	function automatic tok_item_t make_tok(input tok_class_t cls,
			input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len);
		tok_item_t t;
		t.token_class  = cls;
		t.token_start  = TOK_W'(start);
		t.token_length = TOK_W'(len);
		t.last         = 1'b0;
		return t;
	endfunction

	assign accept    = src_valid && !src_stall;
	assign pop       = tok_valid && !tok_stall;
	assign src_stall = count_q > (QA+1)'(QD - 2);
	assign tok_valid = count_q != '0;
	assign tok_item  = queue_q[rd_q];

	// Scan one item: next state and the tokens it closes
	always_comb begin
		logic [CHAR_W-1:0]   c;
		logic                alnum;
		logic                have_sc;
		tok_class_t          sc;
		logic [KW_NUM-1:0]   w_alive;
		logic [POS_BITS-1:0] w_len;
		logic                w_dig;
		logic                w_let;
		logic [POS_BITS-1:0] w_start;
		tok_class_t          cur_cls;

		c        = src_item.char_code;
		alnum    = is_letter(c) || is_digit(c);
		mode_d   = mode_q;
		pos_d    = pos_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		alive_d  = alive_q;
		digit_d  = digit_q;
		letter_d = letter_q;
		res0     = make_tok(CL_NUMBER, '0, '0);
		res1     = res0;
		nres     = 2'd0;
		cur_cls  = word_class(alive_q, plen_q, digit_q, letter_q);

		// Decode one-character tokens
		have_sc = 1'b1;
		case (c)
			8'h2b, 8'h2d, 8'h2a, 8'h2f: sc = CL_OP;
			8'h3d:                      sc = CL_EQUAL;
			8'h28, 8'h7b, 8'h5b:        sc = CL_LBRACE;
			8'h3a:                      sc = CL_KEYWORD;
			8'h29, 8'h7d, 8'h5d:        sc = CL_RBRACE;
			default: begin
				sc      = CL_UNKNOWN;
				have_sc = 1'b0;
			end
		endcase

		// Word base: continue the open word or start a fresh one here
		if (mode_q == MODE_WORD) begin
			w_alive = alive_q;
			w_len   = plen_q;
			w_dig   = digit_q;
			w_let   = letter_q;
			w_start = pstart_q;
		end else begin
			w_alive = '1;
			w_len   = '0;
			w_dig   = 1'b0;
			w_let   = 1'b0;
			w_start = pos_q;
		end
		// Drop keywords that no longer match at this offset
		for (int k = 0; k < KW_NUM; k++) begin
			if (!((w_len < POS_BITS'(KW_LEN[k])) && (kw_char(k, w_len[3:0]) == c))) begin
				w_alive[k] = 1'b0;
			end
		end

		if (src_item.req_type == REQ_END) begin
			// Flush and return to reset
			if (mode_q == MODE_WORD) begin
				res0 = make_tok(cur_cls, pstart_q, plen_q);
				nres = 2'd1;
			end else if (mode_q == MODE_STR) begin
				res0 = make_tok(CL_STRING, pstart_q, plen_q);
				nres = 2'd1;
			end
			mode_d   = MODE_IDLE;
			pos_d    = '0;
			pstart_d = '0;
			plen_d   = '0;
			alive_d  = '1;
			digit_d  = 1'b0;
			letter_d = 1'b0;
		end else if (mode_q == MODE_STR) begin
			plen_d = sat_inc(plen_q);
			if (c == CH_QUOTE) begin
				res0   = make_tok(CL_STRING, pstart_q, plen_d);
				nres   = 2'd1;
				mode_d = MODE_IDLE;
			end
			pos_d = sat_inc(pos_q);
		end else if (alnum) begin
			// Extend or open a word
			mode_d   = MODE_WORD;
			pstart_d = w_start;
			alive_d  = w_alive;
			digit_d  = w_dig || is_digit(c);
			letter_d = w_let || is_letter(c);
			plen_d   = sat_inc(w_len);
			pos_d    = sat_inc(pos_q);
		end else begin
			// Close an open word, then handle the character on its own
			if (mode_q == MODE_WORD) begin
				res0 = make_tok(cur_cls, pstart_q, plen_q);
				nres = 2'd1;
			end
			mode_d = MODE_IDLE;
			if (have_sc) begin
				if (mode_q == MODE_WORD) begin
					res1 = make_tok(sc, pos_q, POS_BITS'(1));
					nres = 2'd2;
				end else begin
					res0 = make_tok(sc, pos_q, POS_BITS'(1));
					nres = 2'd1;
				end
			end else if (c == CH_QUOTE) begin
				mode_d   = MODE_STR;
				pstart_d = pos_q;
				plen_d   = POS_BITS'(1);
			end
			pos_d = sat_inc(pos_q);
		end

		// Mark the final token of this item
		if (nres == 2'd2) begin
			res1.last = 1'b1;
		end else begin
			res0.last = 1'b1;
		end
	end

	// Hold scanner state; advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			alive_q  <= '1;
			digit_q  <= 1'b0;
			letter_q <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			alive_q  <= alive_d;
			digit_q  <= digit_d;
			letter_q <= letter_d;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + QA'(nres);
			end
			if (pop) begin
				rd_q <= rd_q + QA'(1);
			end
			count_q <= count_q + (accept ? (QA+1)'(nres) : '0) - (QA+1)'(pop);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (accept && (nres != 2'd0)) begin
			queue_q[wr_q] <= res0;
		end
		if (accept && (nres == 2'd2)) begin
			queue_q[wr_q + QA'(1)] <= res1;
		end
	end

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword lexer. Characters go in one item at a
// time, with random gaps on the source side and random stalls on the token
// side. A behavioral token predictor follows every accepted character, and
// each token that leaves the block is checked against the oldest predicted
// one. Directed cases, a long output hold-off and a random source stream are
// run in turn.
// ----------------------------------------------------------------------------

module tb_top;
	import klt_pkg::*;

	localparam int unsigned SPAN_MAX = 32'h0000_FFFF;
	localparam int KW_COUNT = 14;
	localparam logic [7:0] QUOTE_CHAR = 8'h22;
	localparam int REPORT_MAX = 10;

	logic clk;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	src_item_t src_item = '0;
	logic tok_stall = 1'b1;
	logic src_stall;
	logic tok_valid;
	tok_item_t tok_item;

	// Predictor copy of the scanner state
	mode_t scan_st;
	int unsigned pos_ctr;
	int unsigned span_start;
	int unsigned span_len;
	logic [KW_COUNT-1:0] kw_live;
	bit got_digit;
	bit got_letter;

	tok_item_t tok_expected[$];
	tok_item_t step_toks[$];
	int err_cnt = 0;
	int scan_items = 0;
	int hold_req = 0;
	bit src_idle_en = 1'b0;
	bit snk_idle_en = 1'b0;

	keyword_lexer_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Token predictor
	// ------------------------------------------------------------------

	function automatic string kw_word(int k);
		case (k)
		0: return "textong";
		1: return "numerong";
		2: return "bilang";
		3: return "let";
		4: return "const";
		5: return "para";
		6: return "sa";
		7: return "mula";
		8: return "hanggang";
		9: return "pamamaraan";
		10: return "na";
		11: return "namayroong";
		12: return "at";
		default: return "katapusan";
		endcase
	endfunction

	function automatic tok_class_t kw_kind(int k);
		case (k)
		0: return CL_STRDECL;
		1: return CL_NUMDECL;
		2, 7: return CL_EQUAL;
		4: return CL_CONSTANT;
		9: return CL_FUNCDECL;
		default: return CL_KEYWORD;
		endcase
	endfunction

	function automatic bit ch_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit ch_alnum(logic [7:0] c);
		return ch_digit(c) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
	endfunction

	// One-character tokens; return 0 for anything else
	function automatic bit ch_single(input logic [7:0] c, output tok_class_t k);
		k = CL_OP;
		case (c)
		"+", "-", "*", "/": k = CL_OP;
		"=": k = CL_EQUAL;
		"(", "{", "[": k = CL_LBRACE;
		":": k = CL_KEYWORD;
		")", "}", "]": k = CL_RBRACE;
		default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic int unsigned bump(int unsigned v);
		return (v >= SPAN_MAX) ? SPAN_MAX : v + 1;
	endfunction

	function void clear_scan();
		scan_st = MODE_IDLE;
		pos_ctr = 0;
		span_start = 0;
		span_len = 0;
		kw_live = '1;
		got_digit = 1'b0;
		got_letter = 1'b0;
	endfunction

	// Add one character to the open word and drop keywords that no longer fit
	function void word_extend(logic [7:0] c);
		string w;
		logic [7:0] kc;
		for (int k = 0; k < KW_COUNT; k++) begin
			w = kw_word(k);
			kc = 8'h00;
			if (span_len < w.len())
				kc = w[span_len];
			if (span_len >= w.len() || kc != c)
				kw_live[k] = 1'b0;
		end
		if (ch_digit(c))
			got_digit = 1'b1;
		else
			got_letter = 1'b1;
		span_len = bump(span_len);
	endfunction

	function tok_class_t word_kind();
		string w;
		for (int k = 0; k < KW_COUNT; k++) begin
			w = kw_word(k);
			if (kw_live[k] && w.len() == span_len)
				return kw_kind(k);
		end
		if (!got_letter)
			return CL_NUMBER;
		if (!got_digit)
			return CL_IDENT;
		return CL_UNKNOWN;
	endfunction

	function void put_tok(tok_class_t k, int unsigned st, int unsigned ln);
		tok_item_t t;
		t.token_class = k;
		t.token_start = TOK_W'(st);
		t.token_length = TOK_W'(ln);
		t.last = 1'b0;
		step_toks = {step_toks, t};
	endfunction

	// Advance the predictor by one accepted item and queue its tokens
	function void scan_item(src_item_t it);
		tok_class_t k;
		logic [7:0] c;
		c = it.char_code;
		step_toks.delete();
		if (it.req_type == REQ_END) begin
			if (scan_st == MODE_WORD)
				put_tok(word_kind(), span_start, span_len);
			else if (scan_st == MODE_STR)
				put_tok(CL_STRING, span_start, span_len);
			clear_scan();
		end else if (scan_st == MODE_STR) begin
			span_len = bump(span_len);
			if (c == QUOTE_CHAR) begin
				put_tok(CL_STRING, span_start, span_len);
				scan_st = MODE_IDLE;
			end
			pos_ctr = bump(pos_ctr);
		end else if (scan_st == MODE_WORD && ch_alnum(c)) begin
			word_extend(c);
			pos_ctr = bump(pos_ctr);
		end else begin
			// close an open word, then treat the character as a fresh start
			if (scan_st == MODE_WORD) begin
				put_tok(word_kind(), span_start, span_len);
				scan_st = MODE_IDLE;
			end
			if (ch_single(c, k)) begin
				put_tok(k, pos_ctr, 1);
			end else if (c == QUOTE_CHAR) begin
				scan_st = MODE_STR;
				span_start = pos_ctr;
				span_len = 1;
			end else if (ch_alnum(c)) begin
				scan_st = MODE_WORD;
				span_start = pos_ctr;
				span_len = 0;
				kw_live = '1;
				got_digit = 1'b0;
				got_letter = 1'b0;
				word_extend(c);
			end
			pos_ctr = bump(pos_ctr);
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		tok_expected = {tok_expected, step_toks};
	endfunction

	// ------------------------------------------------------------------
	// Source side
	// ------------------------------------------------------------------

	task automatic push_src(req_t rq, logic [7:0] c);
		src_item_t tmp;
		tok_class_t k;
		int gap;
		gap = src_idle_en ? $urandom_range(0, 11) : 0;
		tmp.req_type = rq;
		tmp.char_code = c;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_item <= tmp;
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		// count only items that reach the scanner's real work
		if (rq == REQ_END || scan_st != MODE_IDLE || ch_alnum(c) || c == QUOTE_CHAR ||
				ch_single(c, k))
			scan_items++;
		scan_item(tmp);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_src(REQ_CHAR, s[i]);
	endtask

	task automatic push_end();
		push_src(REQ_END, 8'($urandom));
	endtask

	function automatic logic [7:0] rand_alnum();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'("a" + $urandom_range(0, 25));
		if (r == 7)
			return 8'("A" + $urandom_range(0, 25));
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_single();
		string s;
		s = "+-*/=({[:)}]";
		return s[$urandom_range(0, 11)];
	endfunction

	// Any byte that only separates tokens
	function automatic logic [7:0] rand_sep();
		logic [7:0] c;
		tok_class_t k;
		if ($urandom_range(0, 1) == 0)
			return " ";
		do c = 8'($urandom); while (ch_alnum(c) || ch_single(c, k) || c == QUOTE_CHAR);
		return c;
	endfunction

	// One random piece of source text, mostly well-formed
	task automatic push_fragment();
		string w;
		int pick;
		int n;
		int cut;
		bit digits;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			push_text(kw_word($urandom_range(0, KW_COUNT - 1)));
		end else if (pick < 42) begin
			// near miss: keyword with a character changed, cut short or added
			w = kw_word($urandom_range(0, KW_COUNT - 1));
			cut = $urandom_range(1, w.len() - 1);
			case ($urandom_range(0, 2))
			0: begin
				w.putc(cut, rand_alnum());
				push_text(w);
			end
			1: push_text(w.substr(0, cut - 1));
			default: begin
				push_text(w);
				push_src(REQ_CHAR, rand_alnum());
			end
			endcase
		end else if (pick < 54) begin
			// free word, mostly short, now and then past the longest keyword
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 6);
			digits = ($urandom_range(0, 3) == 0);
			repeat (n)
				push_src(REQ_CHAR, digits ? 8'("0" + $urandom_range(0, 9)) : rand_alnum());
		end else if (pick < 68) begin
			push_src(REQ_CHAR, rand_single());
		end else if (pick < 78) begin
			// string of random bytes, usually closed
			push_src(REQ_CHAR, QUOTE_CHAR);
			repeat ($urandom_range(0, 8)) begin
				do c = 8'($urandom); while (c == QUOTE_CHAR);
				push_src(REQ_CHAR, c);
			end
			if ($urandom_range(0, 9) != 0)
				push_src(REQ_CHAR, QUOTE_CHAR);
		end else if (pick < 92) begin
			push_src(REQ_CHAR, rand_sep());
		end else if (pick < 95) begin
			push_end();
		end else begin
			push_src(REQ_CHAR, 8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Token side: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end else begin
				n = snk_idle_en ? $urandom_range(0, 11) : 0;
			end
			if (n > 0) begin
				tok_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			tok_stall <= 1'b0;
			do @(posedge clk); while (!tok_valid);
		end
	end

	// Compare each accepted token with the oldest prediction
	always @(posedge clk) begin
		tok_item_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (tok_expected.size() == 0) begin
				err_cnt++;
				if (err_cnt <= REPORT_MAX)
					$display("%0t: unexpected token class %0d start %0d len %0d last %0b",
						$realtime, tok_item.token_class, tok_item.token_start,
						tok_item.token_length, tok_item.last);
			end else begin
				want = tok_expected.pop_front();
				if (tok_item.token_class !== want.token_class ||
						tok_item.token_start !== want.token_start ||
						tok_item.token_length !== want.token_length ||
						tok_item.last !== want.last) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("%0t: token want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
							$realtime, want.token_class, want.token_start,
							want.token_length, want.last, tok_item.token_class,
							tok_item.token_start, tok_item.token_length, tok_item.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_tokens();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		// keyword closed by a bracket: two tokens from one item
		push_text("at(");
		// mixed word closed by a quote, then a string left open at the end
		push_text("x1\"");
		push_src(REQ_CHAR, 8'hFF);
		push_text("q");
		push_end();
		// end of source with nothing pending
		push_end();
		push_text("Zz");
		push_src(REQ_CHAR, 8'h80);
		push_text("90");
		push_src(REQ_CHAR, 8'h00);
		push_text("+-*/={[:)}]");
		// word flushed by end of source
		push_text("let");
		push_src(REQ_END, 8'hFF);
	endtask

	task automatic test_backpressure();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b1;
		hold_req = 300;
		repeat (40) push_text("na+");
		push_end();
	endtask

	task automatic test_random_source();
		int goal;
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_en = (ph < 2);
			snk_idle_en = (ph % 2 == 0);
			goal = scan_items + 135;
			while (scan_items < goal)
				push_fragment();
		end
		push_end();
	endtask

	task automatic finish_run();
		int guard;
		src_valid <= 1'b0;
		guard = 0;
		while (tok_expected.size() > 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && tok_expected.size() == 0) begin
			$display("end of test: clean");
		end else begin
			if (tok_expected.size() > 0)
				$display("%0d predicted tokens never arrived", tok_expected.size());
			$display("end of test: mismatches");
		end
		$finish;
	endtask

	initial begin
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_tokens();
		test_backpressure();
		test_random_source();
		finish_run();
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
hdl/klt_pkg.sv
hdl/keyword_lexer_tokenizer.sv
test/tb_top.sv
